### hw/rtl/sbaw_pkg.sv
package sbaw_pkg;

    localparam int DATA_W     = 8;
    localparam int STRIDE_W   = 14;
    localparam int COUNT_W    = 24;
    localparam int CODE_W     = 2;
    localparam int ADDR_W     = 38;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_RECORD_STRIDE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_COUNT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE_CODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_STRIDE_CODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION         = 3'd4;

    localparam logic [STRIDE_W-1:0] RESET_RECORD_STRIDE = 14'd16;

    localparam logic DIR_LIN_TO_SWZ = 1'b0;
    localparam logic DIR_SWZ_TO_LIN = 1'b1;
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic [STRIDE_W-1:0] record_stride;
        logic [COUNT_W-1:0]  record_count;
        logic [CODE_W-1:0]   chunk_size_code;
        logic [CODE_W-1:0]   index_stride_code;
        logic                direction;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0]   data;
        logic [COUNT_W-1:0]  rec;
        logic [STRIDE_W-1:0] off;
        logic                bad;
        logic                empty;
        logic                last;
    } beat_t;

    // chunk bytes minus one
    function automatic logic [STRIDE_W-1:0] chunk_mask(input logic [CODE_W-1:0] code);
        logic [STRIDE_W-1:0] m;
        case (code)
            2'd0:    m = 14'd1;
            2'd1:    m = 14'd3;
            2'd2:    m = 14'd7;
            default: m = 14'd15;
        endcase
        return m;
    endfunction

    // records per group minus one
    function automatic logic [COUNT_W-1:0] group_mask(input logic [CODE_W-1:0] code);
        logic [COUNT_W-1:0] m;
        case (code)
            2'd0:    m = 24'd7;
            2'd1:    m = 24'd15;
            2'd2:    m = 24'd31;
            default: m = 24'd63;
        endcase
        return m;
    endfunction

endpackage

### hw/rtl/sbaw_cfg.sv
module sbaw_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sbaw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sbaw_pkg::CFG_DATA_W-1:0]    cfg_data,
    output sbaw_pkg::cfg_t                     cfg,
    output logic [sbaw_pkg::ADDR_W-1:0]        padded
);

    sbaw_pkg::cfg_t                      cfg_reg;
    sbaw_pkg::cfg_t                      cfg_next;
    logic [sbaw_pkg::ADDR_W-1:0]         padded_reg;
    logic [sbaw_pkg::ADDR_W-1:0]         padded_next;
    logic [sbaw_pkg::STRIDE_W:0]         cmask;
    logic [sbaw_pkg::COUNT_W:0]          gmask;
    logic [sbaw_pkg::STRIDE_W:0]         pad_stride;
    logic [sbaw_pkg::COUNT_W:0]          pad_count;
    logic [sbaw_pkg::STRIDE_W+sbaw_pkg::COUNT_W+1:0] product;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                sbaw_pkg::REG_RECORD_STRIDE:
                    cfg_next.record_stride = cfg_data[sbaw_pkg::STRIDE_W-1:0];
                sbaw_pkg::REG_RECORD_COUNT:
                    cfg_next.record_count = cfg_data[sbaw_pkg::COUNT_W-1:0];
                sbaw_pkg::REG_CHUNK_SIZE_CODE:
                    cfg_next.chunk_size_code = cfg_data[sbaw_pkg::CODE_W-1:0];
                sbaw_pkg::REG_INDEX_STRIDE_CODE:
                    cfg_next.index_stride_code = cfg_data[sbaw_pkg::CODE_W-1:0];
                sbaw_pkg::REG_DIRECTION:
                    cfg_next.direction = cfg_data[0];
                default: ;
            endcase
        end
    end

    // round stride up to chunk, count up to group, then multiply
    always_comb
    begin
        cmask       = {1'b0, sbaw_pkg::chunk_mask(cfg_reg.chunk_size_code)};
        gmask       = {1'b0, sbaw_pkg::group_mask(cfg_reg.index_stride_code)};
        pad_stride  = ({1'b0, cfg_reg.record_stride} + cmask) & ~cmask;
        pad_count   = ({1'b0, cfg_reg.record_count} + gmask) & ~gmask;
        product     = pad_stride * pad_count;
        padded_next = product[sbaw_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.record_stride     <= sbaw_pkg::RESET_RECORD_STRIDE;
            cfg_reg.record_count      <= '0;
            cfg_reg.chunk_size_code   <= '0;
            cfg_reg.index_stride_code <= '0;
            cfg_reg.direction         <= sbaw_pkg::DIR_LIN_TO_SWZ;
            padded_reg                <= '0;
        end
        else
        begin
            cfg_reg    <= cfg_next;
            padded_reg <= padded_next;
        end
    end

    assign cfg    = cfg_reg;
    assign padded = padded_reg;

endmodule

### hw/rtl/sbaw_walk.sv
module sbaw_walk (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sbaw_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sbaw_pkg::DATA_W-1:0]    data_in,
    output sbaw_pkg::beat_t                beat,
    output logic                           beat_valid,
    input  logic                           beat_ready
);

    logic [sbaw_pkg::COUNT_W-1:0]  rec_reg;
    logic [sbaw_pkg::COUNT_W-1:0]  rec_next;
    logic [sbaw_pkg::STRIDE_W-1:0] off_reg;
    logic [sbaw_pkg::STRIDE_W-1:0] off_next;
    sbaw_pkg::beat_t               beat_reg;
    sbaw_pkg::beat_t               beat_next;
    logic                          beat_valid_reg;
    logic                          beat_valid_next;
    logic                          accept;
    logic                          bad;
    logic                          empty;
    logic                          end_rec;
    logic                          is_last;

    assign in_ready = !beat_valid_reg || beat_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        bad     = (cfg.record_stride & sbaw_pkg::chunk_mask(cfg.chunk_size_code)) != '0;
        empty   = (cfg.record_stride == '0) || (cfg.record_count == '0);
        end_rec = off_reg >= (cfg.record_stride - 14'd1);
        is_last = end_rec && (rec_reg >= (cfg.record_count - 24'd1));

        beat_next.data  = data_in;
        beat_next.rec   = rec_reg;
        beat_next.off   = off_reg;
        beat_next.bad   = bad;
        beat_next.empty = empty;
        beat_next.last  = empty || is_last;

        rec_next = rec_reg;
        off_next = off_reg;
        if (accept && !bad)
        begin
            if (empty || is_last)
            begin
                rec_next = '0;
                off_next = '0;
            end
            else if (end_rec)
            begin
                rec_next = rec_reg + 24'd1;
                off_next = '0;
            end
            else
            begin
                off_next = off_reg + 14'd1;
            end
        end

        beat_valid_next = accept || (beat_valid_reg && !beat_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg        <= '0;
            off_reg        <= '0;
            beat_valid_reg <= 1'b0;
        end
        else
        begin
            rec_reg        <= rec_next;
            off_reg        <= off_next;
            beat_valid_reg <= beat_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat       = beat_reg;
    assign beat_valid = beat_valid_reg;

    a_bad_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && bad) |=> (rec_reg == $past(rec_reg)) && (off_reg == $past(off_reg)))
        else $error("counters moved on invalid stride");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !bad && (empty || is_last)) |=> (rec_reg == '0) && (off_reg == '0))
        else $error("counters did not wrap after final byte");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_valid_reg && !beat_ready) |=> beat_valid_reg && $stable(beat_reg))
        else $error("stalled beat changed");

endmodule

### hw/rtl/sbaw_addr.sv
module sbaw_addr (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sbaw_pkg::cfg_t                 cfg,
    input  logic [sbaw_pkg::ADDR_W-1:0]    padded,
    input  sbaw_pkg::beat_t                beat,
    input  logic                           beat_valid,
    output logic                           beat_ready,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sbaw_pkg::DATA_W-1:0]    data_out,
    output logic [sbaw_pkg::ADDR_W-1:0]    source_address,
    output logic [sbaw_pkg::ADDR_W-1:0]    dest_address,
    output logic [sbaw_pkg::ADDR_W-1:0]    padded_size,
    output logic                           status,
    output logic                           last
);

    logic                          load;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [sbaw_pkg::DATA_W-1:0]   data_reg;
    logic [sbaw_pkg::DATA_W-1:0]   data_next;
    logic [sbaw_pkg::ADDR_W-1:0]   src_reg;
    logic [sbaw_pkg::ADDR_W-1:0]   src_next;
    logic [sbaw_pkg::ADDR_W-1:0]   dst_reg;
    logic [sbaw_pkg::ADDR_W-1:0]   dst_next;
    logic [sbaw_pkg::ADDR_W-1:0]   padded_reg;
    logic [sbaw_pkg::ADDR_W-1:0]   padded_next;
    logic                          status_reg;
    logic                          status_next;
    logic                          last_reg;
    logic                          last_next;
    logic [sbaw_pkg::STRIDE_W-1:0] cmask;
    logic [sbaw_pkg::COUNT_W-1:0]  gmask;
    logic [2:0]                    gshift;
    logic [2:0]                    cshift;
    logic [sbaw_pkg::COUNT_W-1:0]  rec_hi;
    logic [sbaw_pkg::ADDR_W-1:0]   lin;
    logic [sbaw_pkg::ADDR_W-1:0]   hi_sum;
    logic [sbaw_pkg::ADDR_W-1:0]   swz;

    assign beat_ready = !out_valid_reg || out_ready;
    assign load       = beat_valid && beat_ready;

    always_comb
    begin
        cmask  = sbaw_pkg::chunk_mask(cfg.chunk_size_code);
        gmask  = sbaw_pkg::group_mask(cfg.index_stride_code);
        gshift = 3'd3 + {1'b0, cfg.index_stride_code};
        cshift = 3'd1 + {1'b0, cfg.chunk_size_code};
        rec_hi = beat.rec >> gshift;

        lin    = sbaw_pkg::ADDR_W'(beat.rec) * sbaw_pkg::ADDR_W'(cfg.record_stride)
               + sbaw_pkg::ADDR_W'(beat.off);
        hi_sum = sbaw_pkg::ADDR_W'(rec_hi) * sbaw_pkg::ADDR_W'(cfg.record_stride)
               + sbaw_pkg::ADDR_W'(beat.off & ~cmask);
        swz    = (hi_sum << gshift)
               + (sbaw_pkg::ADDR_W'(beat.rec & gmask) << cshift)
               + sbaw_pkg::ADDR_W'(beat.off & cmask);

        data_next   = beat.data;
        padded_next = padded;
        status_next = sbaw_pkg::STATUS_OK;
        last_next   = beat.last;
        if (cfg.direction == sbaw_pkg::DIR_LIN_TO_SWZ)
        begin
            src_next = lin;
            dst_next = swz;
        end
        else
        begin
            src_next = swz;
            dst_next = lin;
        end

        if (beat.bad)
        begin
            data_next   = '0;
            src_next    = '0;
            dst_next    = '0;
            padded_next = '0;
            status_next = sbaw_pkg::STATUS_INVALID;
            last_next   = 1'b0;
        end
        else if (beat.empty)
        begin
            src_next = '0;
            dst_next = '0;
        end

        out_valid_next = load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg   <= data_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
            padded_reg <= padded_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign data_out       = data_reg;
    assign source_address = src_reg;
    assign dest_address   = dst_reg;
    assign padded_size    = padded_reg;
    assign status         = status_reg;
    assign last           = last_reg;

    a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == sbaw_pkg::STATUS_INVALID))
            |-> (src_reg == '0) && (dst_reg == '0) && (padded_reg == '0) && !last_reg)
        else $error("invalid-stride result carries nonzero fields");

endmodule

### hw/rtl/swizzled_buffer_address_walker.sv
// An accepted byte is registered in the beat register, then in the result register.
// Throughput: one byte per cycle while out_ready is high; the address stage (two
// 24x14 multiplies and adds for each byte) sits between the input register and
// the result register. A stalled result holds; the input register still takes
// the next byte only while it is empty. Reset clears the counters and pipeline
// valids and loads the register reset values (record_stride 16, all others 0).
module swizzled_buffer_address_walker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sbaw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbaw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sbaw_pkg::DATA_W-1:0]    data_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sbaw_pkg::DATA_W-1:0]    data_out,
    output logic [sbaw_pkg::ADDR_W-1:0]    source_address,
    output logic [sbaw_pkg::ADDR_W-1:0]    dest_address,
    output logic [sbaw_pkg::ADDR_W-1:0]    padded_size,
    output logic                           status,
    output logic                           last
);

    sbaw_pkg::cfg_t                cfg;
    logic [sbaw_pkg::ADDR_W-1:0]   padded;
    sbaw_pkg::beat_t               beat;
    logic                          beat_valid;
    logic                          beat_ready;

    sbaw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .padded    (padded)
    );

    sbaw_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_in    (data_in),
        .beat       (beat),
        .beat_valid (beat_valid),
        .beat_ready (beat_ready)
    );

    sbaw_addr u_addr (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .padded         (padded),
        .beat           (beat),
        .beat_valid     (beat_valid),
        .beat_ready     (beat_ready),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .data_out       (data_out),
        .source_address (source_address),
        .dest_address   (dest_address),
        .padded_size    (padded_size),
        .status         (status),
        .last           (last)
    );

endmodule
